### hdl/mdr_pkg.sv
// ----------------------------------------------------------------------------
// mdr_pkg
// Shared widths, status codes and beat types of the multiply-divide unit.
// ----------------------------------------------------------------------------
package mdr_pkg;

    localparam int OPERAND_WIDTH = 64;
    localparam int W  = OPERAND_WIDTH;
    localparam int H  = W / 2;          // low half of a factor
    localparam int HU = W - H;          // high half of a factor
    localparam int XW = 64;             // width of the operand ports
    localparam int STAGES = 2 * W;      // one quotient bit per divider stage
    localparam int QDEPTH = 4;
    localparam int QPW = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_INVALID  = 2'd2
    } t_status;

    // Beat passed from the front part to the divider.
    typedef struct packed {
        logic [2*W-1:0] dividend;
        logic [W-1:0]   divisor;
        logic           sgn;
        logic           inv;
    } t_div_item;

    typedef struct packed {
        logic up;
        logic sgn;
        logic inv;
    } t_ctl;

endpackage

### hdl/mdr_front.sv
// ----------------------------------------------------------------------------
// mdr_front
// Accepts beats, flags invalid operands, forms the exact product and adds
// the ceiling correction.
// ----------------------------------------------------------------------------
module mdr_front import mdr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic [XW-1:0]   i_operand_a,
    input  logic [XW-1:0]   i_operand_b,
    input  logic [XW-1:0]   i_divisor,
    input  logic            i_round_up,
    input  logic            i_signed_result,
    output logic            o_q_push,
    input  logic            i_q_full,
    output t_div_item       o_item
);

    logic              en;
    logic              r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [W-1:0]      r_a1, r_b1;
    logic [W-1:0]      r_c1, r_c2, r_c3, r_c4;
    t_ctl              r_k1, r_k2, r_k3, r_k4, r_k5;
    logic [2*H-1:0]    r_ll;
    logic [W-1:0]      r_lh, r_hl;
    logic [2*HU-1:0]   r_hh;
    logic [2*W-1:0]    r_cat;
    logic [W:0]        r_mid;
    logic [2*W-1:0]    r_prod, r_div;
    logic [W-1:0]      r_c5;
    logic [W-1:0]      a_m, b_m, c_m;

    assign a_m = i_operand_a[W-1:0];
    assign b_m = i_operand_b[W-1:0];
    assign c_m = i_divisor[W-1:0];

    assign en       = !(r_v5 && i_q_full);
    assign o_full   = !en;
    assign o_q_push = r_v5 && !i_q_full;
    assign o_item   = '{dividend: r_div, divisor: r_c5, sgn: r_k5.sgn, inv: r_k5.inv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1      <= a_m;
            r_b1      <= b_m;
            r_c1      <= c_m;
            r_k1.up   <= i_round_up;
            r_k1.sgn  <= i_signed_result;
            r_k1.inv  <= (c_m == '0) ||
                         (i_signed_result && (a_m[W-1] | b_m[W-1] | c_m[W-1]));
            // Four partial products of the half-width factors.
            r_ll <= (2*H)'(r_a1[H-1:0]) * (2*H)'(r_b1[H-1:0]);
            r_lh <= W'(r_a1[H-1:0]) * W'(r_b1[W-1:H]);
            r_hl <= W'(r_a1[W-1:H]) * W'(r_b1[H-1:0]);
            r_hh <= (2*HU)'(r_a1[W-1:H]) * (2*HU)'(r_b1[W-1:H]);
            r_c2 <= r_c1;
            r_k2 <= r_k1;
            // The outer products do not overlap, so they simply abut.
            r_cat <= {r_hh, r_ll};
            r_mid <= (W+1)'(r_lh) + (W+1)'(r_hl);
            r_c3  <= r_c2;
            r_k3  <= r_k2;
            r_prod <= r_cat + ((2*W)'(r_mid) << H);
            r_c4   <= r_c3;
            r_k4   <= r_k3;
            r_div  <= r_prod + (r_k4.up ? (2*W)'(r_c4 - W'(1)) : '0);
            r_c5   <= r_c4;
            r_k5   <= r_k4;
        end
    end

endmodule

### hdl/mdr_queue.sv
// ----------------------------------------------------------------------------
// mdr_queue
// Short queue of product beats between the front part and the divider.
// ----------------------------------------------------------------------------
module mdr_queue import mdr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_div_item  i_item,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_empty,
    output t_div_item  o_item
);

    t_div_item       r_mem [QDEPTH];
    logic [QPW-1:0]  r_wp, r_rp;
    logic [QPW:0]    r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == (QPW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + QPW'(1);
            if (do_pop)  r_rp <= r_rp + QPW'(1);
            r_cnt <= r_cnt + (QPW+1)'(do_push) - (QPW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_item;
    end

endmodule

### hdl/mdr_back.sv
// ----------------------------------------------------------------------------
// mdr_back
// Pipelined restoring divider, one quotient bit per stage, and the result
// register with the limit check.
// ----------------------------------------------------------------------------
module mdr_back import mdr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    input  t_div_item       i_item,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [XW-1:0]   o_quotient,
    output logic [1:0]      o_status
);

    logic               en;
    logic               r_v   [STAGES];
    logic [W-1:0]       r_rem [STAGES];
    logic [2*W-1:0]     r_nq  [STAGES];
    logic [W-1:0]       r_d   [STAGES];
    logic               r_sgn [STAGES];
    logic               r_inv [STAGES];
    logic               r_out_v;
    logic [XW-1:0]      r_quot;
    t_status            r_stat;
    logic [W-1:0]       q_lo, limit;
    logic               over;

    assign en      = !r_out_v || i_pop;
    assign o_q_pop = en && !i_q_empty;
    assign o_empty = !r_out_v;
    assign o_quotient = r_quot;
    assign o_status   = r_stat;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [W-1:0]   rem_in, d_in, rem_nx;
        logic [2*W-1:0] nq_in;
        logic           v_in, sgn_in, inv_in, bit_q;
        logic [W:0]     trial;
        if (k == 0) begin : g_head
            assign v_in   = !i_q_empty;
            assign rem_in = '0;
            assign nq_in  = i_item.dividend;
            assign d_in   = i_item.divisor;
            assign sgn_in = i_item.sgn;
            assign inv_in = i_item.inv;
        end else begin : g_body
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign nq_in  = r_nq[k-1];
            assign d_in   = r_d[k-1];
            assign sgn_in = r_sgn[k-1];
            assign inv_in = r_inv[k-1];
        end
        // The partial remainder is one bit wider than the divisor here.
        assign trial  = {rem_in, nq_in[2*W-1]};
        assign bit_q  = (trial >= {1'b0, d_in});
        assign rem_nx = bit_q ? W'(trial - {1'b0, d_in}) : trial[W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[k] <= rem_nx;
                r_nq[k]  <= {nq_in[2*W-2:0], bit_q};
                r_d[k]   <= d_in;
                r_sgn[k] <= sgn_in;
                r_inv[k] <= inv_in;
            end
        end
    end

    assign q_lo  = r_nq[STAGES-1][W-1:0];
    assign limit = r_sgn[STAGES-1] ? {1'b0, {(W-1){1'b1}}} : {W{1'b1}};
    assign over  = (r_nq[STAGES-1][2*W-1:W] != '0) || (q_lo > limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_v[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_inv[STAGES-1]) begin
                r_quot <= '0;
                r_stat <= ST_INVALID;
            end else begin
                r_quot <= XW'(q_lo);
                r_stat <= over ? ST_OVERFLOW : ST_OK;
            end
        end
    end

endmodule

### hdl/mul_div_round_unit.sv
// ----------------------------------------------------------------------------
// mul_div_round_unit
// Exact multiply-divide with floor or ceiling rounding and a limit check.
// ----------------------------------------------------------------------------
// One beat is accepted every cycle and one result leaves every cycle while
// pop keeps up. A beat passes five front stages (operand check, partial
// products, two summing stages, ceiling correction), a four-entry queue,
// one divider stage per quotient bit (2 * OPERAND_WIDTH stages, 128 at the
// default) and the result register. When pop stalls, the divider pipeline
// holds, the queue fills and full rises once the front part can no longer
// move.
module mul_div_round_unit import mdr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic [XW-1:0]   i_operand_a,
    input  logic [XW-1:0]   i_operand_b,
    input  logic [XW-1:0]   i_divisor,
    input  logic            i_round_up,
    input  logic            i_signed_result,
    output logic            empty,
    input  logic            pop,
    output logic [XW-1:0]   o_quotient,
    output logic [1:0]      o_status
);

    t_div_item  f_item, q_item;
    logic       f_push, q_full, q_empty, q_pop;

    mdr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .i_divisor       (i_divisor),
        .i_round_up      (i_round_up),
        .i_signed_result (i_signed_result),
        .o_q_push        (f_push),
        .i_q_full        (q_full),
        .o_item          (f_item)
    );

    mdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    mdr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_item     (q_item),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_quotient (o_quotient),
        .o_status   (o_status)
    );

endmodule
